>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// assertion with synchronous active-low reset as disable
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// assertion that is checked in every cycle
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> design/drsg_pkg.sv
// ----------------------------------------------------------------------------
// drsg_pkg
// Shared widths, codes, state types and request structs of the disk row
// span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package drsg_pkg;

  localparam int COORD_W     = 14;  // center coordinates, signed
  localparam int RAD_W       = 5;   // radius and half-width
  localparam int DIM_W       = 13;  // grid size registers
  localparam int POS_W       = 12;  // output row / column
  localparam int EXT_W       = 15;  // signed working width for row / column sums
  localparam int DEC_W       = 10;  // midpoint decision variable, signed
  localparam int OFS_W       = 7;   // signed row offset, -radius .. radius+1
  localparam int TBL_DEPTH   = 1 << RAD_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;

  localparam logic [DIM_W-1:0] GRID_DIM_MAX = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BUILD,
    PH_SCAN
  } phase_t;

  typedef enum logic [1:0] {
    OC_IDLE,
    OC_UPPER,
    OC_LOWER
  } oct_state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_PRIME,
    SP_RUN,
    SP_FLUSH
  } span_state_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radius;
  } oct_req_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] cc;
    logic signed [COORD_W-1:0] cr;
    logic [RAD_W-1:0]          radius;
    logic [DIM_W-1:0]          gw;
    logic [DIM_W-1:0]          gh;
  } scan_req_t;

endpackage

`default_nettype wire

>>> design/drsg_octant.sv
// ----------------------------------------------------------------------------
// drsg_octant
// Midpoint circle recurrence on one shared adder, filling the half-width
// table. Each step runs in an upper and a lower state; the table read port is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module drsg_octant (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire drsg_pkg::oct_req_t          req,
  output logic                             done,
  input  wire logic [drsg_pkg::RAD_W-1:0]  rd_addr,
  output logic [drsg_pkg::RAD_W-1:0]       rd_data
);
  import drsg_pkg::*;

  oct_state_t              st_r, st_nxt;
  logic [RAD_W-1:0]        x_r, x_nxt;
  logic [RAD_W-1:0]        y_r, y_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic                    flag_r, flag_nxt;

  logic [RAD_W-1:0]        mem [TBL_DEPTH];
  logic [RAD_W-1:0]        rd_data_r;

  logic signed [DEC_W-1:0] addend;
  logic signed [DEC_W-1:0] sum;
  logic                    we;
  logic [RAD_W-1:0]        wa;
  logic [RAD_W-1:0]        wd;
  logic                    cont;

  // one adder: upper half adds 4-4y, lower half adds 4x+6
  always_comb begin
    if (st_r == OC_UPPER) begin
      addend = DEC_W'(4) - DEC_W'({y_r, 2'b00});
    end else begin
      addend = DEC_W'({x_r, 2'b00}) + DEC_W'(6);
    end
    sum = dec_r + addend;
  end

  // next step runs while x+1 <= y after the optional decrement
  assign cont = ({1'b0, x_r} + (RAD_W+1)'(1) + (RAD_W+1)'(flag_r)) <= {1'b0, y_r};

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    dec_nxt  = dec_r;
    flag_nxt = flag_r;
    we       = 1'b0;
    wa       = y_r;
    wd       = x_r;
    done     = 1'b0;
    case (st_r)
      OC_IDLE: begin
        if (req.start) begin
          x_nxt    = '0;
          y_nxt    = req.radius;
          dec_nxt  = DEC_W'(3) - DEC_W'({req.radius, 1'b0});
          flag_nxt = 1'b0;
          st_nxt   = OC_UPPER;
        end
      end
      OC_UPPER: begin
        we       = 1'b1;
        wa       = y_r;
        wd       = x_r;
        flag_nxt = ~dec_r[DEC_W-1];
        if (!dec_r[DEC_W-1]) begin
          dec_nxt = sum;
        end
        st_nxt   = OC_LOWER;
      end
      OC_LOWER: begin
        // a later write at index x carries y >= x and so is the larger width
        we      = 1'b1;
        wa      = x_r;
        wd      = y_r;
        dec_nxt = sum;
        x_nxt   = x_r + RAD_W'(1);
        y_nxt   = y_r - RAD_W'(flag_r);
        if (cont) begin
          st_nxt = OC_UPPER;
        end else begin
          st_nxt = OC_IDLE;
          done   = 1'b1;
        end
      end
      default: begin
        st_nxt = OC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= OC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dec_r  <= dec_nxt;
    flag_r <= flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/drsg_span.sv
// ----------------------------------------------------------------------------
// drsg_span
// Row scan from top to bottom: clips each row's span to the grid, holds one
// span back so the final word can carry tlast, and drives the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module drsg_span (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire drsg_pkg::scan_req_t               req,
  output logic                                   done,
  output logic [drsg_pkg::RAD_W-1:0]             rd_addr,
  input  wire logic [drsg_pkg::RAD_W-1:0]        rd_data,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // row [11:0], col_first [23:12], col_last [35:24], zero pad [39:36]
  output logic [drsg_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // empty_res [0]
  output logic                                   out_tuser,
  output logic                                   out_tlast
);
  import drsg_pkg::*;

  function automatic logic [RAD_W-1:0] ofs_abs(input logic signed [OFS_W-1:0] v);
    logic signed [OFS_W-1:0] m;
    m = v[OFS_W-1] ? -v : v;
    return m[RAD_W-1:0];
  endfunction

  span_state_t             st_r, st_nxt;
  logic signed [OFS_W-1:0] d_r, d_nxt;

  logic                    pend_v_r, pend_v_nxt;
  logic [POS_W-1:0]        pend_row_r, pend_row_nxt;
  logic [POS_W-1:0]        pend_c0_r, pend_c0_nxt;
  logic [POS_W-1:0]        pend_c1_r, pend_c1_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        out_row_r, out_row_nxt;
  logic [POS_W-1:0]        out_c0_r, out_c0_nxt;
  logic [POS_W-1:0]        out_c1_r, out_c1_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic                    out_last_r, out_last_nxt;

  logic signed [OFS_W-1:0] r_s;
  logic signed [OFS_W-1:0] d_inc;
  logic signed [EXT_W-1:0] row_s;
  logic signed [EXT_W-1:0] w_s;
  logic signed [EXT_W-1:0] c0, c1, c0c, c1c;
  logic signed [EXT_W-1:0] gw_m1, gh_s;
  logic                    row_ok;
  logic                    span_ok;
  logic                    slot_free;
  logic                    adv;

  assign r_s   = signed'(OFS_W'(req.radius));
  assign d_inc = d_r + OFS_W'(1);

  always_comb begin
    row_s   = EXT_W'(req.cr) + EXT_W'(d_r);
    w_s     = signed'(EXT_W'(rd_data));
    c0      = EXT_W'(req.cc) - w_s;
    c1      = EXT_W'(req.cc) + w_s;
    gw_m1   = signed'(EXT_W'(req.gw)) - EXT_W'(1);
    gh_s    = signed'(EXT_W'(req.gh));
    row_ok  = !row_s[EXT_W-1] && (row_s < gh_s);
    c0c     = c0[EXT_W-1] ? '0 : c0;
    c1c     = (c1 > gw_m1) ? gw_m1 : c1;
    span_ok = row_ok && (c0c <= c1c);
  end

  assign slot_free = !out_valid_r || out_tready;
  // a skipped row never waits; a found span waits only if one is already held
  // and the output word has not yet been taken
  assign adv = !span_ok || !pend_v_r || slot_free;

  always_comb begin
    st_nxt        = st_r;
    d_nxt         = d_r;
    rd_addr       = ofs_abs(d_r);
    done          = 1'b0;
    pend_v_nxt    = pend_v_r;
    pend_row_nxt  = pend_row_r;
    pend_c0_nxt   = pend_c0_r;
    pend_c1_nxt   = pend_c1_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_row_nxt   = out_row_r;
    out_c0_nxt    = out_c0_r;
    out_c1_nxt    = out_c1_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    case (st_r)
      SP_IDLE: begin
        if (req.start) begin
          d_nxt      = -r_s;
          pend_v_nxt = 1'b0;
          st_nxt     = SP_PRIME;
        end
      end
      SP_PRIME: begin
        st_nxt = SP_RUN;
      end
      SP_RUN: begin
        if (adv) begin
          rd_addr = ofs_abs(d_inc);
          d_nxt   = d_inc;
          if (span_ok) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = pend_row_r;
              out_c0_nxt    = pend_c0_r;
              out_c1_nxt    = pend_c1_r;
              out_empty_nxt = 1'b0;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_row_nxt = row_s[POS_W-1:0];
            pend_c0_nxt  = c0c[POS_W-1:0];
            pend_c1_nxt  = c1c[POS_W-1:0];
          end
          if (d_r == r_s) begin
            st_nxt = SP_FLUSH;
          end
        end
      end
      SP_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_empty_nxt = !pend_v_r;
          if (pend_v_r) begin
            out_row_nxt = pend_row_r;
            out_c0_nxt  = pend_c0_r;
            out_c1_nxt  = pend_c1_r;
          end else begin
            out_row_nxt = '0;
            out_c0_nxt  = '0;
            out_c1_nxt  = '0;
          end
          pend_v_nxt = 1'b0;
          done       = 1'b1;
          st_nxt     = SP_IDLE;
        end
      end
      default: begin
        st_nxt = SP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SP_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_c0_r   <= pend_c0_nxt;
    pend_c1_r   <= pend_c1_nxt;
    out_row_r   <= out_row_nxt;
    out_c0_r    <= out_c0_nxt;
    out_c1_r    <= out_c1_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 3*POS_W){1'b0}}, out_c1_r, out_c0_r, out_row_r};
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_empty_is_last, clk, rst_n, out_valid_r && out_empty_r |-> out_last_r)
  `ASSERT_CLK(a_idle_no_pend, clk, rst_n, (st_r == SP_IDLE) |-> !pend_v_r)
  `ASSERT_CLK(a_stall_holds_row, clk, rst_n, (st_r == SP_RUN) && !adv |=> $stable(d_r))
  `ASSERT_CLK(a_ofs_in_range, clk, rst_n, (st_r == SP_RUN) |-> (d_r <= r_s))

endmodule

`default_nettype wire

>>> design/disk_row_span_generator.sv
// ----------------------------------------------------------------------------
// disk_row_span_generator
// Filled-disk row spans from a center and radius, clipped to a grid.
// ----------------------------------------------------------------------------
// One request (center column, center row, radius R) is taken while the block
// is idle; in_tready stays low until its last span word has been handed to
// the output register. The midpoint recurrence runs on a single shared adder,
// filling a 32-entry half-width table; the row scan then visits all 2R+1 rows
// at one row per cycle unless output back-pressure holds it, reading that
// table through its registered port. Each word gives row, first and last
// column; tlast marks the final word of a request, and a disk that covers
// no cell yields one word with tuser (empty) set and zero data. Grid size
// registers above 4096 act as 4096; zero means no cells.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_row_span_generator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // center_col [13:0], center_row [27:14], radius [32:28], zero pad [39:33]
  input  wire logic [drsg_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // row [11:0], col_first [23:12], col_last [35:24], zero pad [39:36]
  output logic [drsg_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // empty_res [0]
  output logic                                    out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [drsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [drsg_pkg::DIM_W-1:0]         cfg_data
);
  import drsg_pkg::*;

  logic [DIM_W-1:0]          gw_cfg_r;
  logic [DIM_W-1:0]          gh_cfg_r;

  phase_t                    ph_r, ph_nxt;
  logic signed [COORD_W-1:0] cc_r;
  logic signed [COORD_W-1:0] cr_r;
  logic [RAD_W-1:0]          rad_r;
  logic [DIM_W-1:0]          gw_r;
  logic [DIM_W-1:0]          gh_r;

  logic                      in_acc;
  logic [RAD_W-1:0]          in_radius;
  oct_req_t                  oct_req;
  logic                      oct_done;
  scan_req_t                 scan_req;
  logic                      scan_done;
  logic [RAD_W-1:0]          tbl_addr;
  logic [RAD_W-1:0]          tbl_data;

  assign cfg_ready = 1'b1;
  assign in_tready = (ph_r == PH_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_radius = in_tdata[2*COORD_W+RAD_W-1:2*COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_cfg_r <= GRID_DIM_MAX;
      gh_cfg_r <= GRID_DIM_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  gw_cfg_r <= cfg_data;
        CFG_GRID_HEIGHT: gh_cfg_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request word latched with the grid size clamped to the largest grid
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cc_r  <= signed'(in_tdata[COORD_W-1:0]);
      cr_r  <= signed'(in_tdata[2*COORD_W-1:COORD_W]);
      rad_r <= in_radius;
      gw_r  <= (gw_cfg_r > GRID_DIM_MAX) ? GRID_DIM_MAX : gw_cfg_r;
      gh_r  <= (gh_cfg_r > GRID_DIM_MAX) ? GRID_DIM_MAX : gh_cfg_r;
    end
  end

  always_comb begin
    ph_nxt          = ph_r;
    oct_req.start   = 1'b0;
    oct_req.radius  = in_radius;
    scan_req.start  = 1'b0;
    scan_req.cc     = cc_r;
    scan_req.cr     = cr_r;
    scan_req.radius = rad_r;
    scan_req.gw     = gw_r;
    scan_req.gh     = gh_r;
    case (ph_r)
      PH_IDLE: begin
        if (in_acc) begin
          oct_req.start = 1'b1;
          ph_nxt        = PH_BUILD;
        end
      end
      PH_BUILD: begin
        if (oct_done) begin
          scan_req.start = 1'b1;
          ph_nxt         = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (scan_done) begin
          ph_nxt = PH_IDLE;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  drsg_octant u_octant (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (oct_req),
    .done    (oct_done),
    .rd_addr (tbl_addr),
    .rd_data (tbl_data)
  );

  drsg_span u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (scan_req),
    .done       (scan_done),
    .rd_addr    (tbl_addr),
    .rd_data    (tbl_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> tb/sv/disk_row_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_row_span_checker
// Watches the request, span and register channels of the disk row span
// generator, predicts the span words of every accepted request and compares
// each output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module disk_row_span_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  // center_col [13:0], center_row [27:14], radius [32:28], zero pad [39:33]
  input  wire logic [drsg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  // row [11:0], col_first [23:12], col_last [35:24], zero pad [39:36]
  input  wire logic [drsg_pkg::OUT_TDATA_W-1:0] out_tdata,
  // empty_res [0]
  input  wire logic                             out_tuser,
  input  wire logic                             out_tlast,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [drsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [drsg_pkg::DIM_W-1:0]       cfg_data,
  output int                                    fail_count,
  output int                                    pending_words
);
  import drsg_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col_first;
    logic [POS_W-1:0] col_last;
    logic             empty_res;
    logic             last_of_run;
  } span_word_t;

  span_word_t       span_q[$];
  logic [DIM_W-1:0] grid_w;
  logic [DIM_W-1:0] grid_h;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    grid_w        = GRID_DIM_MAX;
    grid_h        = GRID_DIM_MAX;
  end

  // Midpoint circle half-widths, then one span per visible row, top down.
  function automatic void predict_spans(input logic signed [COORD_W-1:0] cc,
                                        input logic signed [COORD_W-1:0] cr,
                                        input logic [RAD_W-1:0] rad);
    int         half[TBL_DEPTH];
    int         x, y, dec, r, k, d;
    int         ccv, crv, gw, gh, row, c0, c1;
    bit         held;
    span_word_t word;
    ccv  = cc;
    crv  = cr;
    r    = rad;
    gw   = (grid_w > GRID_DIM_MAX) ? GRID_DIM_MAX : grid_w;
    gh   = (grid_h > GRID_DIM_MAX) ? GRID_DIM_MAX : grid_h;
    held = 1'b0;
    word = '0;
    for (k = 0; k < TBL_DEPTH; k++) half[k] = 0;
    x   = 0;
    y   = r;
    dec = 3 - 2 * r;
    while (x <= y) begin
      if (half[y] < x) half[y] = x;
      if (half[x] < y) half[x] = y;
      if (dec >= 0) begin
        dec = dec - 4 * y + 4;
        y--;
      end
      dec = dec + 4 * x + 6;
      x++;
    end
    for (d = -r; d <= r; d++) begin
      row = crv + d;
      c0  = ccv - half[d < 0 ? -d : d];
      c1  = ccv + half[d < 0 ? -d : d];
      if (c0 < 0) c0 = 0;
      if (c1 > gw - 1) c1 = gw - 1;
      if (row >= 0 && row < gh && c0 <= c1) begin
        // previous span is not the last one: release it
        if (held) span_q.push_back(word);
        word.row         = row[POS_W-1:0];
        word.col_first   = c0[POS_W-1:0];
        word.col_last    = c1[POS_W-1:0];
        word.empty_res   = 1'b0;
        word.last_of_run = 1'b0;
        held             = 1'b1;
      end
    end
    if (!held) word.empty_res = 1'b1;
    word.last_of_run = 1'b1;
    span_q.push_back(word);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    span_word_t want;
    if (!rst_n) begin
      span_q.delete();
      grid_w = GRID_DIM_MAX;
      grid_h = GRID_DIM_MAX;
    end else begin
      if (out_tvalid && out_tready) begin
        if (span_q.size() == 0) begin
          $error("unexpected span word: row %0d, col_first %0d, col_last %0d",
                 out_tdata[11:0], out_tdata[23:12], out_tdata[35:24]);
          fail_count++;
        end else begin
          want = span_q.pop_front();
          check_field("row", want.row, out_tdata[11:0]);
          check_field("col_first", want.col_first, out_tdata[23:12]);
          check_field("col_last", want.col_last, out_tdata[35:24]);
          check_field("empty_res", want.empty_res, out_tuser);
          check_field("last_of_run", want.last_of_run, out_tlast);
        end
      end
      if (in_tvalid && in_tready)
        predict_spans(in_tdata[13:0], in_tdata[27:14], in_tdata[32:28]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_w = cfg_data;
          CFG_GRID_HEIGHT: grid_h = cfg_data;
          default: ;
        endcase
      end
    end
    pending_words = span_q.size();
  end

endmodule

>>> tb/sv/tb_disk_row_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_row_span_generator
// Drives disk requests and grid size writes into the span generator, with
// random idle cycles on both streams; the checker beside the block predicts
// and compares every span word.
// ----------------------------------------------------------------------------

module tb_disk_row_span_generator;
  import drsg_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 41;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [DIM_W-1:0]       cfg_data   = '0;

  int fail_count;
  int pending_words;
  int cycle_cnt = 0;
  bit no_idle   = 1'b0;
  int eff_w     = 4096;
  int eff_h     = 4096;

  disk_row_span_generator dut (.*);

  disk_row_span_checker u_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) out_tready <= no_idle || ($urandom_range(0, 99) >= 32);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid is left high after the handshake; the next call or drain moves it
  task automatic send_disk(input int cc, input int cr, input int rad);
    logic [IN_TDATA_W-1:0] word;
    word        = '0;
    word[13:0]  = cc[13:0];
    word[27:14] = cr[13:0];
    word[32:28] = rad[4:0];
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_index <= idx;
    cfg_data  <= val[DIM_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_grid(input int w, input int h);
    drain();
    cfg_write(CFG_GRID_WIDTH, w);
    cfg_write(CFG_GRID_HEIGHT, h);
    cfg_valid <= 1'b0;
    eff_w = (w > 4096) ? 4096 : w;
    eff_h = (h > 4096) ? 4096 : h;
  endtask

  // mostly centres over the grid and a margin of about the radius; some anywhere in the field
  task automatic random_disk();
    int r, cc, cr;
    r = $urandom_range(0, 31);
    if ($urandom_range(0, 99) < 15) begin
      cc = $urandom_range(0, 16383) - 8192;
      cr = $urandom_range(0, 16383) - 8192;
    end else begin
      cc = $urandom_range(0, eff_w + 2 * r + 3) - r - 2;
      cr = $urandom_range(0, eff_h + 2 * r + 3) - r - 2;
    end
    send_disk(cc, cr, r);
  endtask

  initial begin
    int gw_set[PHASES];
    int gh_set[PHASES];
    int item_no;
    gw_set  = '{4096, 8191, 64, 1, 4096, 17, 0, 0};
    gh_set  = '{4096, 8191, 48, 4096, 1, 9, 300, 0};
    item_no = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid, 4096 x 4096
    send_disk(2048, 2048, 0);
    send_disk(2048, 2048, 31);
    send_disk(0, 0, 31);
    send_disk(4095, 4095, 31);
    send_disk(-8192, -8192, 31);
    send_disk(8191, 8191, 31);
    send_disk(-8192, 100, 0);
    send_disk(100, 8191, 5);
    send_disk(-3, 50, 5);
    send_disk(4098, 50, 5);
    send_disk(50, -3, 5);
    send_disk(50, 4099, 6);
    send_disk(-32, 10, 31);
    send_disk(4127, 10, 31);

    // oversized registers act as the maximum grid
    set_grid(8191, 8191);
    send_disk(4094, 4094, 3);
    drain();
    cfg_write(CFG_SPARE_A, 5);
    cfg_write(CFG_SPARE_B, 7);
    cfg_valid <= 1'b0;
    send_disk(4094, 10, 3);

    set_grid(0, 0);
    send_disk(0, 0, 0);
    set_grid(1, 1);
    send_disk(0, 0, 0);
    send_disk(0, 0, 31);
    send_disk(1, 1, 1);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        gw_set[p] = $urandom_range(1, 200);
        gh_set[p] = $urandom_range(1, 200);
      end
      set_grid(gw_set[p], gh_set[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (item_no >= 120 && item_no < 170);
        random_disk();
        item_no++;
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
